### hdl/rgb_to_hsv_pixel_top_assert.svh
// Assertion macros shared by the conversion pipeline.
// Each macro uses the clk and arst_n of the module it is expanded in.
`ifndef RGB_TO_HSV_PIXEL_TOP_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define HSV_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsv_pixel: same-cycle check failed");
`define HSV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsv_pixel: next-cycle check failed");
`else
`define HSV_ASSERT_IMPL(label, ante, cons)
`define HSV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/rgb2hsv_pkg.sv
package rgb2hsv_pkg;

	localparam int CHANNEL_BITS  = 8;
	localparam int HUE_FRAC_BITS = 6;

	localparam int SAT_FULL   = (1 << CHANNEL_BITS) - 1;
	localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
	localparam int HUE_CIRCLE = 360 << HUE_FRAC_BITS;

	localparam int CH_W  = CHANNEL_BITS;
	localparam int HUE_W = $clog2(HUE_CIRCLE);

	// quotient bits: one per cell
	localparam int SAT_Q_W = CH_W;
	localparam int HUE_Q_W = $clog2(HUE_SECTOR + 1);
	localparam int Q_W     = (SAT_Q_W > HUE_Q_W) ? SAT_Q_W : HUE_Q_W;
	localparam int NCELL   = Q_W;

	// divisors are 2*max and 2*delta
	localparam int DIV_W = CH_W + 1;
	localparam int DEN_W = DIV_W + Q_W - 1;
	localparam int REM_W = DEN_W + 1;

	// hue arithmetic before wrap needs one bit over the circle
	localparam int HSUM_W = $clog2(2 * HUE_CIRCLE);

	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	typedef struct packed {
		logic             valid;
		logic             undef;
		logic [CH_W-1:0]  bright;
		logic             neg;
		logic [1:0]       sector;
		logic [REM_W-1:0] sat_rem;
		logic [DEN_W-1:0] sat_den;
		logic [Q_W-1:0]   sat_q;
		logic [REM_W-1:0] hue_rem;
		logic [DEN_W-1:0] hue_den;
		logic [Q_W-1:0]   hue_q;
	} cell_t;

endpackage

### hdl/rgb2hsv_front.sv
module rgb2hsv_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req,
	input  logic [rgb2hsv_pkg::CH_W-1:0]  red,
	input  logic [rgb2hsv_pkg::CH_W-1:0]  green,
	input  logic [rgb2hsv_pkg::CH_W-1:0]  blue,
	output rgb2hsv_pkg::cell_t            head_s2
);
	import rgb2hsv_pkg::*;

	logic [CH_W-1:0] mx, mn, pos, ngv, diff;
	logic [1:0]      sector;

	logic            valid_s1;
	logic [CH_W-1:0] mx_s1, delta_s1, diff_s1;
	logic            neg_s1;
	logic [1:0]      sector_s1;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;

		// ties go red, then green
		priority if (red == mx) begin
			sector = SEC_RED;
			pos    = green;
			ngv    = blue;
		end else if (green == mx) begin
			sector = SEC_GREEN;
			pos    = blue;
			ngv    = red;
		end else begin
			sector = SEC_BLUE;
			pos    = red;
			ngv    = green;
		end
		diff = (pos >= ngv) ? pos - ngv : ngv - pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1     <= mx;
		delta_s1  <= mx - mn;
		diff_s1   <= diff;
		neg_s1    <= (pos < ngv);
		sector_s1 <= sector;
	end

	// numerators carry the rounding term: (2*k*x + d) / (2*d)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s2 <= '0;
		end else begin
			head_s2.valid   <= valid_s1;
			head_s2.undef   <= (delta_s1 == '0);
			head_s2.bright  <= mx_s1;
			head_s2.neg     <= neg_s1;
			head_s2.sector  <= sector_s1;
			head_s2.sat_rem <= REM_W'(delta_s1) * REM_W'(2 * SAT_FULL) + REM_W'(mx_s1);
			head_s2.sat_den <= DEN_W'({mx_s1, 1'b0}) << (Q_W - 1);
			head_s2.sat_q   <= '0;
			head_s2.hue_rem <= REM_W'(diff_s1) * REM_W'(2 * HUE_SECTOR) + REM_W'(delta_s1);
			head_s2.hue_den <= DEN_W'({delta_s1, 1'b0}) << (Q_W - 1);
			head_s2.hue_q   <= '0;
		end
	end

endmodule

### hdl/rgb2hsv_cell.sv
module rgb2hsv_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  rgb2hsv_pkg::cell_t d_i,
	output rgb2hsv_pkg::cell_t stage_q
);
	import rgb2hsv_pkg::*;

	logic sat_ge, hue_ge;

	// one restoring step per divider; divisor walks right one bit per cell
	assign sat_ge = (d_i.sat_rem >= REM_W'(d_i.sat_den));
	assign hue_ge = (d_i.hue_rem >= REM_W'(d_i.hue_den));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else begin
			stage_q.valid   <= d_i.valid;
			stage_q.undef   <= d_i.undef;
			stage_q.bright  <= d_i.bright;
			stage_q.neg     <= d_i.neg;
			stage_q.sector  <= d_i.sector;
			stage_q.sat_rem <= sat_ge ? d_i.sat_rem - REM_W'(d_i.sat_den) : d_i.sat_rem;
			stage_q.sat_den <= d_i.sat_den >> 1;
			stage_q.sat_q   <= {d_i.sat_q[Q_W-2:0], sat_ge};
			stage_q.hue_rem <= hue_ge ? d_i.hue_rem - REM_W'(d_i.hue_den) : d_i.hue_rem;
			stage_q.hue_den <= d_i.hue_den >> 1;
			stage_q.hue_q   <= {d_i.hue_q[Q_W-2:0], hue_ge};
		end
	end

endmodule

### hdl/rgb_to_hsv_pixel_top.sv
// RGB to HSV converter, one pixel per clock. A request is taken on any cycle with
// start high; busy is never raised. Each request yields exactly one result, flagged
// by done for a single cycle, once the request has passed the max/min and numerator
// set-up registers (s1, s2), a chain of 12 divider cells (one quotient bit each,
// saturation and hue side by side), then the hue wrap and output register. The
// receiver cannot hold results off, so it must take every done cycle. Hue is in
// 1/64 degree; hue_undefined marks black or grey pixels, which report hue and
// saturation as zero.
module rgb_to_hsv_pixel_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rgb2hsv_pkg::CH_W-1:0]  red,
	input  logic [rgb2hsv_pkg::CH_W-1:0]  green,
	input  logic [rgb2hsv_pkg::CH_W-1:0]  blue,
	output logic                          done,
	output logic [rgb2hsv_pkg::HUE_W-1:0] hue,
	output logic [rgb2hsv_pkg::CH_W-1:0]  saturation,
	output logic [rgb2hsv_pkg::CH_W-1:0]  brightness,
	output logic                          hue_undefined
);
	import rgb2hsv_pkg::*;

	cell_t              chain [0:NCELL];
	cell_t              last;
	logic [HSUM_W-1:0]  base, mag, hue_sum;

	assign busy = 1'b0;

	rgb2hsv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (start),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.head_s2 (chain[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		rgb2hsv_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.d_i     (chain[i]),
			.stage_q (chain[i+1])
		);
	end

	assign last = chain[NCELL];
	assign mag  = HSUM_W'(last.hue_q);

	always_comb begin
		unique case (last.sector)
			SEC_RED:   base = '0;
			SEC_GREEN: base = HSUM_W'(2 * HUE_SECTOR);
			SEC_BLUE:  base = HSUM_W'(4 * HUE_SECTOR);
			default:   base = '0;
		endcase

		priority if (!last.neg) begin
			hue_sum = base + mag;
		end else if (mag > base) begin
			hue_sum = base + HSUM_W'(HUE_CIRCLE) - mag;
		end else begin
			hue_sum = base - mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		brightness    <= last.bright;
		hue_undefined <= last.undef;
		hue           <= last.undef ? '0 : hue_sum[HUE_W-1:0];
		saturation    <= last.undef ? '0 : last.sat_q[CH_W-1:0];
	end

	`include "rgb_to_hsv_pixel_top_assert.svh"

	`HSV_ASSERT_NEXT(a_done_follows, last.valid, done)
	`HSV_ASSERT_NEXT(a_no_stray_done, !last.valid, !done)
	`HSV_ASSERT_IMPL(a_undef_zeroed, done && hue_undefined, hue == '0 && saturation == '0)
	`HSV_ASSERT_IMPL(a_hue_in_circle, done && !hue_undefined, hue < HUE_W'(HUE_CIRCLE))
	`HSV_ASSERT_IMPL(a_sat_nonzero, done && !hue_undefined, saturation != '0 && brightness != '0)

endmodule
